// ===== hw/rtl/pfe_pkg.sv =====
// Package for the postfix expression evaluator: stack sizing, character codes,
// and the request/response types of the iterative divide/power unit.
// No dependencies.
`default_nettype none

package pfe_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int DATA_W      = 32;
	localparam int CHAR_W      = 8;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [IDX_W-1:0]  idx_t;

	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_STAR  = 8'h2A;
	localparam char_t CH_SLASH = 8'h2F;
	localparam char_t CH_CARET = 8'h5E;

	localparam data_t VAL_EMPTY = '1;  // value of a pop from an empty stack (-1)
	localparam data_t VAL_ONE   = data_t'(1);

	typedef enum logic {
		ITER_DIV,
		ITER_POW
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} pfe_iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pfe_iter_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfe_stream_if.sv =====
// Valid/ready stream interfaces for the postfix evaluator: character beats in,
// result beats out. Depends on pfe_pkg.
`default_nettype none

interface pfe_sym_if;
	logic          valid;
	logic          ready;
	pfe_pkg::char_t ch;
	logic          last;

	modport source (output valid, ch, last, input ready);
	modport sink   (input valid, ch, last, output ready);
endinterface

interface pfe_res_if;
	logic           valid;
	logic           ready;
	pfe_pkg::data_t value;
	logic           error;

	modport source (output valid, value, error, input ready);
	modport sink   (input valid, value, error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pfe_stack_ram.sv =====
// Operand stack storage: one write port, one read port, registered read data.
// Depends on pfe_pkg.
`default_nettype none

module pfe_stack_ram (
	input  wire            clk,
	input  wire            wr_en,
	input  pfe_pkg::idx_t  wr_addr,
	input  pfe_pkg::data_t wr_data,
	input  wire            rd_en,
	input  pfe_pkg::idx_t  rd_addr,
	output pfe_pkg::data_t rd_data
);
	import pfe_pkg::*;

	data_t mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pfe_iter_unit.sv =====
// Iterative arithmetic unit: restoring signed division truncating toward zero,
// and square-and-multiply power for non-negative exponents, one bit per cycle.
// Depends on pfe_pkg.
`default_nettype none

module pfe_iter_unit (
	input  wire                    clk,
	input  wire                    arst_n,
	input  pfe_pkg::pfe_iter_req_t req,
	input  pfe_pkg::data_t         a,
	input  pfe_pkg::data_t         b,
	output pfe_pkg::pfe_iter_rsp_t rsp,
	output pfe_pkg::data_t         result
);
	import pfe_pkg::*;

	localparam int STEP_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	iter_op_t          op_q;
	logic              neg_q;
	data_t             divisor_q;
	data_t             rem_q;
	data_t             quo_q;
	data_t             acc_q;
	data_t             sq_q;
	data_t             exp_q;

	logic [DATA_W:0] shifted;
	logic [DATA_W:0] trial;

	always_comb begin
		shifted = {rem_q, quo_q[DATA_W-1]};
		trial   = shifted - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			step_q    <= '0;
			op_q      <= ITER_DIV;
			neg_q     <= 1'b0;
			divisor_q <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			acc_q     <= '0;
			sq_q      <= '0;
			exp_q     <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(DATA_W - 1));
			if (req.start) begin
				busy_q    <= 1'b1;
				step_q    <= '0;
				op_q      <= req.op;
				neg_q     <= a[DATA_W-1] ^ b[DATA_W-1];
				divisor_q <= b[DATA_W-1] ? (data_t'(0) - b) : b;
				rem_q     <= '0;
				quo_q     <= a[DATA_W-1] ? (data_t'(0) - a) : a;
				acc_q     <= VAL_ONE;
				sq_q      <= a;
				exp_q     <= b;
			end else if (busy_q) begin
				if (op_q == ITER_DIV) begin
					if (!trial[DATA_W]) begin
						rem_q <= trial[DATA_W-1:0];
						quo_q <= {quo_q[DATA_W-2:0], 1'b1};
					end else begin
						rem_q <= shifted[DATA_W-1:0];
						quo_q <= {quo_q[DATA_W-2:0], 1'b0};
					end
				end else begin
					if (exp_q[0]) begin
						acc_q <= acc_q * sq_q;
					end
					sq_q  <= sq_q * sq_q;
					exp_q <= {1'b0, exp_q[DATA_W-1:1]};
				end
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		if (op_q == ITER_DIV) begin
			result = neg_q ? (data_t'(0) - quo_q) : quo_q;
		end else begin
			result = acc_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/postfix_expression_evaluator.sv =====
// Postfix expression evaluator top level: sequencer around the operand stack
// memory and the iterative divide/power unit. Depends on pfe_pkg,
// pfe_stream_if, pfe_stack_ram and pfe_iter_unit.
`default_nettype none

// One character beat is taken at a time. A digit goes from the idle state
// through the push and finish states back to idle; any other character first
// makes two pops, each of which waits for the stack memory's registered read
// (a pop of an empty stack skips that wait and yields -1). '/' with a non-zero
// divisor and '^' with a non-negative exponent also wait for the 32-step
// divide/power unit. A beat with last set then pops the top and loads the result
// register (no pop when the stack is empty), and waits in the finish state while
// an earlier result beat is still not taken. The stack has STACK_DEPTH entries;
// pushing onto a full stack drops the value and sets the sticky error, as do
// division by zero and zero to a negative power. No clearing pass is needed
// after reset.
module postfix_expression_evaluator (
	input wire        clk,
	input wire        arst_n,
	pfe_sym_if.sink   symbols,
	pfe_res_if.source results
);
	import pfe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_R,
		S_WAIT_R,
		S_POP_L,
		S_WAIT_L,
		S_EXEC,
		S_BUSY,
		S_PUSH,
		S_FINISH,
		S_WAIT_OUT
	} state_t;

	state_t state_q;
	char_t  ch_q;
	logic   last_q;
	cnt_t   cnt_q;
	logic   err_q;
	data_t  r_q;
	data_t  l_q;
	data_t  res_q;
	logic   out_valid_q;
	data_t  out_value_q;
	logic   out_error_q;

	logic          is_digit;
	logic          slot_free;
	logic          load_out;
	logic          wr_en;
	logic          rd_en;
	cnt_t          cnt_dec;
	data_t         rd_data;
	pfe_iter_req_t iter_req;
	pfe_iter_rsp_t iter_rsp;
	data_t         iter_result;

	assign is_digit  = (symbols.ch >= CH_ZERO) && (symbols.ch <= CH_NINE);
	assign slot_free = !out_valid_q || results.ready;
	assign cnt_dec   = cnt_q - cnt_t'(1);
	// A new result beat is loaded this cycle.
	assign load_out  = (state_q == S_WAIT_OUT)
		|| ((state_q == S_FINISH) && last_q && slot_free && (cnt_q == '0));

	always_comb begin
		wr_en = (state_q == S_PUSH) && (cnt_q < cnt_t'(STACK_DEPTH));
		rd_en = (((state_q == S_POP_R) || (state_q == S_POP_L)) && (cnt_q != '0))
			|| ((state_q == S_FINISH) && last_q && slot_free && (cnt_q != '0));
		iter_req.start = 1'b0;
		iter_req.op    = ITER_DIV;
		if (state_q == S_EXEC) begin
			if ((ch_q == CH_SLASH) && (r_q != '0)) begin
				iter_req.start = 1'b1;
			end else if ((ch_q == CH_CARET) && !r_q[DATA_W-1]) begin
				iter_req.start = 1'b1;
				iter_req.op    = ITER_POW;
			end
		end
	end

	pfe_stack_ram u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (res_q),
		.rd_en   (rd_en),
		.rd_addr (cnt_dec[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	pfe_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iter_req),
		.a      (l_q),
		.b      (r_q),
		.rsp    (iter_rsp),
		.result (iter_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			r_q         <= '0;
			l_q         <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_error_q <= 1'b0;
		end else begin
			if (results.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (symbols.valid) begin
						ch_q   <= symbols.ch;
						last_q <= symbols.last;
						if (is_digit) begin
							res_q   <= data_t'(symbols.ch - CH_ZERO);
							state_q <= S_PUSH;
						end else begin
							state_q <= S_POP_R;
						end
					end
				end
				S_POP_R: begin
					if (cnt_q == '0) begin
						r_q     <= VAL_EMPTY;
						state_q <= S_POP_L;
					end else begin
						cnt_q   <= cnt_dec;
						state_q <= S_WAIT_R;
					end
				end
				S_WAIT_R: begin
					r_q     <= rd_data;
					state_q <= S_POP_L;
				end
				S_POP_L: begin
					if (cnt_q == '0) begin
						l_q     <= VAL_EMPTY;
						state_q <= S_EXEC;
					end else begin
						cnt_q   <= cnt_dec;
						state_q <= S_WAIT_L;
					end
				end
				S_WAIT_L: begin
					l_q     <= rd_data;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					unique case (ch_q)
						CH_PLUS: begin
							res_q   <= l_q + r_q;
							state_q <= S_PUSH;
						end
						CH_MINUS: begin
							res_q   <= l_q - r_q;
							state_q <= S_PUSH;
						end
						CH_STAR: begin
							res_q   <= l_q * r_q;
							state_q <= S_PUSH;
						end
						CH_SLASH: begin
							if (r_q == '0) begin
								err_q   <= 1'b1;
								res_q   <= '0;
								state_q <= S_PUSH;
							end else begin
								state_q <= S_BUSY;
							end
						end
						CH_CARET: begin
							if (r_q[DATA_W-1]) begin
								// Negative exponent: only bases 1 and -1 survive truncation.
								state_q <= S_PUSH;
								if (l_q == VAL_ONE) begin
									res_q <= VAL_ONE;
								end else if (l_q == VAL_EMPTY) begin
									res_q <= r_q[0] ? VAL_EMPTY : VAL_ONE;
								end else begin
									res_q <= '0;
									if (l_q == '0) begin
										err_q <= 1'b1;
									end
								end
							end else begin
								state_q <= S_BUSY;
							end
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_BUSY: begin
					if (iter_rsp.done) begin
						res_q   <= iter_result;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (cnt_q >= cnt_t'(STACK_DEPTH)) begin
						err_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + cnt_t'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (slot_free) begin
						if (cnt_q == '0) begin
							out_valid_q <= 1'b1;
							out_value_q <= VAL_EMPTY;
							out_error_q <= err_q;
							err_q       <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_WAIT_OUT;
						end
					end
				end
				S_WAIT_OUT: begin
					out_valid_q <= 1'b1;
					out_value_q <= rd_data;
					out_error_q <= err_q;
					cnt_q       <= '0;
					err_q       <= 1'b0;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign symbols.ready = (state_q == S_IDLE);
	assign results.valid = out_valid_q;
	assign results.value = out_value_q;
	assign results.error = out_error_q;

`ifndef SYNTHESIS
	// The fill count never passes the stack depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// The result register is free whenever the popped top arrives.
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT_OUT) |-> !out_valid_q)
		else $error("result overwritten before it was taken");

	// The iterative unit only finishes while the sequencer waits for it.
	a_iter_done: assert property (@(posedge clk) disable iff (!arst_n)
		iter_rsp.done |-> (state_q == S_BUSY))
		else $error("iterative unit finished outside its wait state");

	// No character beat is taken while the iterative unit is running.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		iter_rsp.busy |-> !symbols.ready)
		else $error("beat accepted while the iterative unit is busy");
`endif

endmodule

`default_nettype wire
